// ===== rtl/core/ielp_pkg.sv =====
// ---------------------------------------------------------------------------
// ielp_pkg: shared types and constants of the information element parser
// Element identifiers, one-hot state codes, output codes, the element
// completion record and the helper functions used by the parser blocks.
// ---------------------------------------------------------------------------
`default_nettype none

package ielp_pkg;

  // Element identifiers that the parser recognizes.
  localparam logic [7:0] EID_COUNTRY  = 8'd7;
  localparam logic [7:0] EID_BSS_LOAD = 8'd11;
  localparam logic [7:0] EID_HT_CAP   = 8'd45;
  localparam logic [7:0] EID_RSN      = 8'd48;
  localparam logic [7:0] EID_HT_OP    = 8'd61;
  localparam logic [7:0] EID_VHT_OP   = 8'd192;
  localparam logic [7:0] EID_VENDOR   = 8'd221;
  localparam logic [7:0] EID_EXT      = 8'd255;

  // Extension tag of the HE operation element.
  localparam logic [7:0]  HE_OP_TAG    = 8'd36;
  // Vendor OUI 00:50:F2 with type 4, as the first four value bytes (LSB first).
  localparam logic [31:0] WPS_OUI_TYPE = 32'h04F2_5000;

  // RSN capability bits for management frame protection.
  localparam int unsigned PMF_REQUIRED_BIT = 6;
  localparam int unsigned PMF_CAPABLE_BIT  = 7;

  // Minimum element lengths.
  localparam logic [7:0] LEN_HT_OP    = 8'd2;
  localparam logic [7:0] LEN_VHT_OP   = 8'd1;
  localparam logic [7:0] LEN_HE_OP    = 8'd1;
  localparam logic [7:0] LEN_VENDOR   = 8'd4;
  localparam logic [7:0] LEN_BSS_LOAD = 8'd3;
  localparam logic [7:0] LEN_COUNTRY  = 8'd2;
  localparam logic [7:0] LEN_RSN      = 8'd8;

  // Frequency below which a legacy network is reported as 802.11g.
  localparam logic [12:0] FREQ_2G_LIMIT = 13'd2500;

  // RSN field walk: first count after version and group cipher, saturation.
  localparam logic [10:0] RSN_FIRST_POS = 11'd6;
  localparam logic [10:0] RSN_POS_MAX   = 11'h7FF;

  // PHY generation codes.
  localparam logic [2:0] PHY_G  = 3'd0;
  localparam logic [2:0] PHY_A  = 3'd1;
  localparam logic [2:0] PHY_N  = 3'd2;
  localparam logic [2:0] PHY_AC = 3'd3;
  localparam logic [2:0] PHY_AX = 3'd4;

  // Channel width codes.
  localparam logic [1:0] WIDTH_20  = 2'd0;
  localparam logic [1:0] WIDTH_40  = 2'd1;
  localparam logic [1:0] WIDTH_80  = 2'd2;
  localparam logic [1:0] WIDTH_160 = 2'd3;

  // Management frame protection codes.
  localparam logic [1:0] PMF_UNKNOWN  = 2'd0;
  localparam logic [1:0] PMF_OFF      = 2'd1;
  localparam logic [1:0] PMF_OPTIONAL = 2'd2;
  localparam logic [1:0] PMF_REQUIRED = 2'd3;

  // HT/VHT operation field values.
  localparam logic [1:0] HT_SEC_ABOVE = 2'd1;
  localparam logic [1:0] HT_SEC_BELOW = 2'd3;
  localparam logic [7:0] VHT_CW_80    = 8'd1;
  localparam logic [7:0] VHT_CW_160   = 8'd2;
  localparam logic [7:0] VHT_CW_80P80 = 8'd3;

  // Absent markers for the load fields.
  localparam logic [16:0] STATIONS_NONE = 17'h1FFFF;
  localparam logic [7:0]  UTIL_NONE     = 8'hFF;

  // Element framing phase.
  typedef enum logic [2:0] {
    PH_TYPE = 3'b001,
    PH_LEN  = 3'b010,
    PH_VAL  = 3'b100
  } phase_t;

  // Walk through the RSN element toward the capability field.
  typedef enum logic [3:0] {
    RSN_PAIR = 4'b0001,
    RSN_AKM  = 4'b0010,
    RSN_CAP  = 4'b0100,
    RSN_DONE = 4'b1000
  } rsn_stage_t;

  // Record of an element that completes with the current byte.
  typedef struct packed {
    logic        done;
    logic [7:0]  etype;
    logic [7:0]  elen;
    logic [31:0] head;
    logic        cap_vld;
    logic [15:0] cap;
  } commit_t;

  // One result of the parser.
  typedef struct packed {
    logic [2:0]         phy_mode;
    logic [1:0]         width_code;
    logic signed [16:0] bss_stations;
    logic signed [7:0]  channel_util;
    logic [1:0]         pmf_mode;
    logic               wps_present;
    logic [7:0]         country_first;
    logic [7:0]         country_second;
  } result_t;

  // Whitespace bytes that are trimmed from the country string.
  function automatic logic is_space(input logic [7:0] c);
    is_space = ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32) ||
               (c == 8'h85) || (c == 8'hA0);
  endfunction

  // Utilization percent floor(b * 100 / 255). The quotient comes from a
  // reciprocal multiply by 25700 / 2^16, which is low by at most one, and a
  // single remainder check corrects it.
  function automatic logic [7:0] util_pct(input logic [7:0] b);
    logic [22:0] prod;
    logic [6:0]  q;
    logic [15:0] scaled;
    logic [15:0] rem;
    prod   = {15'd0, b} * 23'd25700;
    q      = prod[22:16];
    scaled = {8'd0, b} * 16'd100;
    rem    = scaled - ({9'd0, q} * 16'd255);
    if (rem >= 16'd255) begin
      util_pct = {1'b0, q} + 8'd1;
    end else begin
      util_pct = {1'b0, q};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wlan_info_element_parser_core.sv =====
// ---------------------------------------------------------------------------
// wlan_info_element_parser_core: beacon information element parser
// Streams a beacon's information elements in byte by byte and reports the
// PHY generation, channel width, BSS load, PMF mode, WPS presence and
// country code when the last byte of the blob arrives.
// ---------------------------------------------------------------------------
// The block takes one byte per clock. Each byte is held in an input register
// and parsed from there; the result of a blob is written into the output
// register when its last byte leaves the input register, and is offered
// from there until the output side takes it.
// Throughput is one byte per clock, set by the single parse stage. Bytes keep
// flowing while a finished result waits at the output; only a closing byte
// waits in the input register until the output side takes the earlier
// result, and in_tready stays low meanwhile.
// A byte whose in_tuser bit is low is skipped but its in_tlast still closes
// the blob. An element counts only when its final value byte has arrived.
// After each result all parse and kept state returns to its reset values.
// ---------------------------------------------------------------------------
`default_nettype none

module wlan_info_element_parser_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input byte stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // ie_byte[7:0], frequency_mhz[20:8], zero pad
  input  wire logic [0:0]  in_tuser,   // byte_valid
  input  wire logic        in_tlast,
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata   // phy_mode[2:0], width_code[4:3],
                                       // bss_stations[21:5], channel_util[29:22],
                                       // pmf_mode[31:30], wps_present[32],
                                       // country_first[40:33], country_second[48:41],
                                       // zero pad
);

  logic        in_vld_r;
  logic [7:0]  byte_r;
  logic [12:0] freq_r;
  logic        bvalid_r;
  logic        last_r;

  logic        out_vld_r;
  logic [55:0] out_data_r;

  logic        out_free;
  logic        consume;
  logic        step;
  logic        flush;

  ielp_pkg::commit_t commit;
  ielp_pkg::result_t result;

  // Stage handshake: the held item moves on unless it closes a blob while
  // the output register is still occupied.
  assign out_free  = !out_vld_r || out_tready;
  assign consume   = in_vld_r && (!last_r || out_free);
  assign in_tready = !in_vld_r || consume;
  assign step      = consume && bvalid_r;
  assign flush     = consume && last_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (consume) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r   <= in_tdata[7:0];
      freq_r   <= in_tdata[20:8];
      bvalid_r <= in_tuser[0];
      last_r   <= in_tlast;
    end
  end

  ielp_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .flush    (flush),
    .byte_i   (byte_r),
    .commit_o (commit)
  );

  ielp_kept u_kept (
    .clk           (clk),
    .rst_n         (rst_n),
    .commit_i      (commit),
    .flush         (flush),
    .frequency_mhz (freq_r),
    .result_o      (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (flush) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flush) begin
      out_data_r <= {7'd0,
                     result.country_second,
                     result.country_first,
                     result.wps_present,
                     result.pmf_mode,
                     result.channel_util,
                     result.bss_stations,
                     result.width_code,
                     result.phy_mode};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/ielp_parse.sv =====
// ---------------------------------------------------------------------------
// ielp_parse: element framing and value capture
// Splits the byte stream into type, length and value records, keeps the
// first four value bytes, follows the RSN field walk, and flags the byte on
// which an element completes.
// ---------------------------------------------------------------------------
`default_nettype none

module ielp_parse (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,     // a valid byte is consumed
  input  wire logic             flush,    // last item consumed, restart
  input  wire logic [7:0]       byte_i,
  output ielp_pkg::commit_t     commit_o
);

  ielp_pkg::phase_t     phase_r, phase_nxt;
  logic [7:0]           type_r, type_nxt;
  logic [7:0]           len_r, len_nxt;
  logic [7:0]           off_r, off_nxt;
  logic [31:0]          head_r, head_nxt;
  logic [10:0]          pos_r, pos_nxt;
  ielp_pkg::rsn_stage_t stage_r, stage_nxt;
  logic [7:0]           low_r, low_nxt;
  logic [15:0]          cap_r, cap_nxt;
  logic                 cap_vld_r, cap_vld_nxt;

  logic        done;
  logic [11:0] pos_p1;
  logic [15:0] count;
  logic [18:0] skip_sum;
  logic [10:0] skip_pos;

  // Next RSN position: skip the count field and four bytes per suite.
  assign pos_p1   = {1'b0, pos_r} + 12'd1;
  assign count    = {byte_i, low_r};
  assign skip_sum = {8'd0, pos_r} + 19'd2 + {1'b0, count, 2'b00};
  assign skip_pos = (skip_sum > {8'd0, ielp_pkg::RSN_POS_MAX}) ?
                    ielp_pkg::RSN_POS_MAX : skip_sum[10:0];

  // Byte handling per framing phase.
  always_comb begin
    phase_nxt   = phase_r;
    type_nxt    = type_r;
    len_nxt     = len_r;
    off_nxt     = off_r;
    head_nxt    = head_r;
    pos_nxt     = pos_r;
    stage_nxt   = stage_r;
    low_nxt     = low_r;
    cap_nxt     = cap_r;
    cap_vld_nxt = cap_vld_r;
    done        = 1'b0;

    if (step) begin
      unique case (phase_r)
        ielp_pkg::PH_TYPE: begin
          type_nxt  = byte_i;
          phase_nxt = ielp_pkg::PH_LEN;
        end
        ielp_pkg::PH_LEN: begin
          len_nxt     = byte_i;
          off_nxt     = 8'd0;
          head_nxt    = 32'd0;
          pos_nxt     = ielp_pkg::RSN_FIRST_POS;
          stage_nxt   = ielp_pkg::RSN_PAIR;
          low_nxt     = 8'd0;
          cap_nxt     = 16'd0;
          cap_vld_nxt = 1'b0;
          if (byte_i == 8'd0) begin
            done      = 1'b1;
            phase_nxt = ielp_pkg::PH_TYPE;
          end else begin
            phase_nxt = ielp_pkg::PH_VAL;
          end
        end
        ielp_pkg::PH_VAL: begin
          // Keep the first four value bytes.
          if (off_r < 8'd4) begin
            head_nxt[{off_r[1:0], 3'b000} +: 8] = byte_i;
          end
          // RSN walk: low byte, then high byte of each 16-bit field.
          if (stage_r != ielp_pkg::RSN_DONE) begin
            if ({3'b000, off_r} == pos_r) begin
              low_nxt = byte_i;
            end else if ({4'b0000, off_r} == pos_p1) begin
              unique case (stage_r)
                ielp_pkg::RSN_PAIR: begin
                  pos_nxt   = skip_pos;
                  stage_nxt = ielp_pkg::RSN_AKM;
                end
                ielp_pkg::RSN_AKM: begin
                  pos_nxt   = skip_pos;
                  stage_nxt = ielp_pkg::RSN_CAP;
                end
                ielp_pkg::RSN_CAP: begin
                  cap_nxt     = count;
                  cap_vld_nxt = 1'b1;
                  stage_nxt   = ielp_pkg::RSN_DONE;
                end
                default: begin
                  stage_nxt = ielp_pkg::RSN_DONE;
                end
              endcase
            end
          end
          off_nxt = off_r + 8'd1;
          if (off_nxt >= len_r) begin
            done      = 1'b1;
            phase_nxt = ielp_pkg::PH_TYPE;
          end
        end
        default: begin
          phase_nxt = ielp_pkg::PH_TYPE;
        end
      endcase
    end
  end

  // The completion record carries the values after this byte.
  always_comb begin
    commit_o.done    = done;
    commit_o.etype   = type_nxt;
    commit_o.elen    = len_nxt;
    commit_o.head    = head_nxt;
    commit_o.cap_vld = cap_vld_nxt;
    commit_o.cap     = cap_nxt;
  end

  // Parse state; the last item of a blob returns it to reset.
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      phase_r   <= ielp_pkg::PH_TYPE;
      type_r    <= 8'd0;
      len_r     <= 8'd0;
      off_r     <= 8'd0;
      head_r    <= 32'd0;
      pos_r     <= ielp_pkg::RSN_FIRST_POS;
      stage_r   <= ielp_pkg::RSN_PAIR;
      low_r     <= 8'd0;
      cap_r     <= 16'd0;
      cap_vld_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      type_r    <= type_nxt;
      len_r     <= len_nxt;
      off_r     <= off_nxt;
      head_r    <= head_nxt;
      pos_r     <= pos_nxt;
      stage_r   <= stage_nxt;
      low_r     <= low_nxt;
      cap_r     <= cap_nxt;
      cap_vld_r <= cap_vld_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ielp_kept.sv =====
// ---------------------------------------------------------------------------
// ielp_kept: kept network properties and result assembly
// Applies completed elements to the kept properties, later overriding earlier
// (generation flags accumulate), and forms the result from them.
// ---------------------------------------------------------------------------
`default_nettype none

module ielp_kept (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ielp_pkg::commit_t commit_i,
  input  wire logic              flush,
  input  wire logic [12:0]       frequency_mhz,
  output ielp_pkg::result_t      result_o
);

  logic [2:0]  gen_r, gen_nxt;        // bit 0 HT, bit 1 VHT, bit 2 HE
  logic [1:0]  width_r, width_nxt;
  logic [16:0] sta_r, sta_nxt;
  logic [7:0]  util_r, util_nxt;
  logic [1:0]  pmf_r, pmf_nxt;
  logic        wps_r, wps_nxt;
  logic [7:0]  cc0_r, cc0_nxt;
  logic [7:0]  cc1_r, cc1_nxt;

  logic [7:0] hb0, hb1, hb2;

  assign hb0 = commit_i.head[7:0];
  assign hb1 = commit_i.head[15:8];
  assign hb2 = commit_i.head[23:16];

  // Apply a completed element.
  always_comb begin
    gen_nxt   = gen_r;
    width_nxt = width_r;
    sta_nxt   = sta_r;
    util_nxt  = util_r;
    pmf_nxt   = pmf_r;
    wps_nxt   = wps_r;
    cc0_nxt   = cc0_r;
    cc1_nxt   = cc1_r;

    if (commit_i.done) begin
      if (commit_i.etype == ielp_pkg::EID_HT_OP && commit_i.elen >= ielp_pkg::LEN_HT_OP) begin
        gen_nxt[0] = 1'b1;
        if (hb1[1:0] == ielp_pkg::HT_SEC_ABOVE || hb1[1:0] == ielp_pkg::HT_SEC_BELOW) begin
          width_nxt = ielp_pkg::WIDTH_40;
        end
      end else if (commit_i.etype == ielp_pkg::EID_HT_CAP) begin
        gen_nxt[0] = 1'b1;
      end else if (commit_i.etype == ielp_pkg::EID_VHT_OP &&
                   commit_i.elen >= ielp_pkg::LEN_VHT_OP) begin
        gen_nxt[1] = 1'b1;
        if (hb0 == ielp_pkg::VHT_CW_80) begin
          width_nxt = ielp_pkg::WIDTH_80;
        end else if (hb0 == ielp_pkg::VHT_CW_160 || hb0 == ielp_pkg::VHT_CW_80P80) begin
          width_nxt = ielp_pkg::WIDTH_160;
        end
      end else if (commit_i.etype == ielp_pkg::EID_EXT &&
                   commit_i.elen >= ielp_pkg::LEN_HE_OP && hb0 == ielp_pkg::HE_OP_TAG) begin
        gen_nxt[2] = 1'b1;
      end else if (commit_i.etype == ielp_pkg::EID_VENDOR &&
                   commit_i.elen >= ielp_pkg::LEN_VENDOR &&
                   commit_i.head == ielp_pkg::WPS_OUI_TYPE) begin
        wps_nxt = 1'b1;
      end else if (commit_i.etype == ielp_pkg::EID_BSS_LOAD &&
                   commit_i.elen >= ielp_pkg::LEN_BSS_LOAD) begin
        sta_nxt  = {1'b0, hb1, hb0};
        util_nxt = ielp_pkg::util_pct(hb2);
      end else if (commit_i.etype == ielp_pkg::EID_COUNTRY &&
                   commit_i.elen >= ielp_pkg::LEN_COUNTRY) begin
        cc0_nxt = ielp_pkg::is_space(hb0) ? 8'd0 : hb0;
        cc1_nxt = ielp_pkg::is_space(hb1) ? 8'd0 : hb1;
      end else if (commit_i.etype == ielp_pkg::EID_RSN &&
                   commit_i.elen >= ielp_pkg::LEN_RSN && commit_i.cap_vld) begin
        if (commit_i.cap[ielp_pkg::PMF_REQUIRED_BIT]) begin
          pmf_nxt = ielp_pkg::PMF_REQUIRED;
        end else if (commit_i.cap[ielp_pkg::PMF_CAPABLE_BIT]) begin
          pmf_nxt = ielp_pkg::PMF_OPTIONAL;
        end else begin
          pmf_nxt = ielp_pkg::PMF_OFF;
        end
      end
    end
  end

  // Result from the properties as they stand after this item.
  always_comb begin
    if (gen_nxt[2]) begin
      result_o.phy_mode = ielp_pkg::PHY_AX;
    end else if (gen_nxt[1]) begin
      result_o.phy_mode = ielp_pkg::PHY_AC;
    end else if (gen_nxt[0]) begin
      result_o.phy_mode = ielp_pkg::PHY_N;
    end else if (frequency_mhz < ielp_pkg::FREQ_2G_LIMIT) begin
      result_o.phy_mode = ielp_pkg::PHY_G;
    end else begin
      result_o.phy_mode = ielp_pkg::PHY_A;
    end
    result_o.width_code     = width_nxt;
    result_o.bss_stations   = sta_nxt;
    result_o.channel_util   = util_nxt;
    result_o.pmf_mode       = pmf_nxt;
    result_o.wps_present    = wps_nxt;
    result_o.country_first  = cc0_nxt;
    result_o.country_second = cc1_nxt;
  end

  // Kept properties; the last item of a blob returns them to reset.
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      gen_r   <= 3'd0;
      width_r <= ielp_pkg::WIDTH_20;
      sta_r   <= ielp_pkg::STATIONS_NONE;
      util_r  <= ielp_pkg::UTIL_NONE;
      pmf_r   <= ielp_pkg::PMF_UNKNOWN;
      wps_r   <= 1'b0;
      cc0_r   <= 8'd0;
      cc1_r   <= 8'd0;
    end else begin
      gen_r   <= gen_nxt;
      width_r <= width_nxt;
      sta_r   <= sta_nxt;
      util_r  <= util_nxt;
      pmf_r   <= pmf_nxt;
      wps_r   <= wps_nxt;
      cc0_r   <= cc0_nxt;
      cc1_r   <= cc1_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ielp_checker.sv =====
// ---------------------------------------------------------------------------
// ielp_checker: port-level checks of the information element parser
// Watches the top-level ports for result timing, field ranges and the
// holding of a stalled result transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module ielp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its data.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // A new result traces back to a closing input transaction.
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a closing input transaction");

  // PHY code and utilization stay in their ranges.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= 3'd4) &&
                   ((out_tdata[29:22] <= 8'd100) || (out_tdata[29:22] == 8'hFF)))
    else $error("result field out of range");

endmodule

bind wlan_info_element_parser_core ielp_checker u_ielp_checker (.*);

`default_nettype wire
